>>> hw/rtl/serial_frame_deframer_checksum_unit_assert.svh
// Assertion macros for the serial frame deframer checksum unit.
`ifndef SERIAL_FRAME_DEFRAMER_CHECKSUM_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_CHECKSUM_UNIT_ASSERT_SVH

// Property must hold on every clock outside reset.
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define SFD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/sfd_pkg.sv
// Package with types and constants for the serial frame deframer checksum unit.
package sfd_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 64;
  localparam int unsigned FRAME_OVERHEAD  = 3;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OFFSET_W = 6;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd126;
  localparam logic [BYTE_W-1:0] CHECK_BASE   = 8'hFF;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_PROGRESS = 2'd0;
  localparam status_t ST_GOOD     = 2'd1;
  localparam status_t ST_BAD      = 2'd2;
  localparam status_t ST_ABANDON  = 2'd3;

  localparam logic REG_START_MARKER = 1'b0;

endpackage

>>> hw/rtl/serial_frame_deframer_checksum_unit.sv
// Top level of the serial frame deframer checksum unit.
// Usage:
//   in_*  : received bytes, one per word. in_tdata holds rx_byte; in_tuser set
//           means the line went idle (byte ignored, partial frame dropped).
//   out_* : body and checksum bytes with their frame offset. out_tlast marks
//           the checksum byte or an abandon word; out_tuser carries the status
//           (in progress, good, checksum bad, abandoned).
//   cfg_* : APB register 0 at address 0 holds the start marker (reset 0x7E).
// Marker and length bytes are consumed without a result. A length whose frame
// would exceed 64 bytes, or an idle word inside a frame, yields one abandon
// word and the unit hunts for the marker again.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput is one word per cycle while out_tready stays high, set by the single
// pass of compare, count and add that sits between the input handshake and the output register.
// When the receiver stalls, the output register holds its word and in_tready
// drops until that word is taken. Reset returns to hunting, clears the output
// valid and restores the start marker.
module serial_frame_deframer_checksum_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sfd_pkg::IN_TDATA_W-1:0]      in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] line_idle
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sfd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] data_byte, [13:8] byte_offset
  output logic                                out_tlast,
  output logic [sfd_pkg::STATUS_W-1:0]        out_tuser,  // [1:0] frame_status
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);
  import sfd_pkg::*;

  `include "serial_frame_deframer_checksum_unit_assert.svh"

  logic [BYTE_W-1:0]   marker_r;
  phase_t              phase_r, phase_nxt;
  logic [OFFSET_W-1:0] count_r, count_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;

  logic                out_valid_r;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic                last_r, last_nxt;
  status_t             status_r, status_nxt;
  logic                emit;

  logic                in_fire;
  logic [BYTE_W-1:0]   rx_byte;
  logic                line_idle;
  logic [BYTE_W:0]     len_total;
  logic [SIZE_W-1:0]   count_plus;
  logic [BYTE_W-1:0]   check;
  logic                cfg_wr;

  localparam logic [SIZE_W-1:0]   SIZE_RESET = SIZE_W'(MAX_FRAME_BYTES);
  localparam logic [BYTE_W:0]     MAX_TOTAL  = (BYTE_W+1)'(MAX_FRAME_BYTES);
  localparam logic [BYTE_W:0]     OVERHEAD   = (BYTE_W+1)'(FRAME_OVERHEAD);
  localparam logic [OFFSET_W-1:0] OFS_LEN    = OFFSET_W'(1);
  localparam logic [OFFSET_W-1:0] OFS_BODY   = OFFSET_W'(2);

  assign rx_byte    = in_tdata[BYTE_W-1:0];
  assign line_idle  = in_tuser;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign len_total  = {1'b0, rx_byte} + OVERHEAD;
  assign count_plus = {1'b0, count_r} + SIZE_W'(1);
  assign check      = CHECK_BASE - sum_r;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    size_nxt   = size_r;
    sum_nxt    = sum_r;
    emit       = 1'b0;
    data_nxt   = '0;
    offset_nxt = count_r;
    last_nxt   = 1'b0;
    status_nxt = ST_PROGRESS;
    if (line_idle) begin
      if (phase_r == PH_LEN || phase_r == PH_BODY) begin
        emit       = 1'b1;
        last_nxt   = 1'b1;
        status_nxt = ST_ABANDON;
        phase_nxt  = PH_HUNT;
        count_nxt  = '0;
        size_nxt   = SIZE_RESET;
        sum_nxt    = '0;
      end else begin
        phase_nxt = PH_HUNT;
      end
    end else begin
      case (phase_r)
        PH_LEN: begin
          if (len_total > MAX_TOTAL) begin
            emit       = 1'b1;
            offset_nxt = OFS_LEN;
            last_nxt   = 1'b1;
            status_nxt = ST_ABANDON;
            phase_nxt  = PH_HUNT;
            count_nxt  = '0;
            size_nxt   = SIZE_RESET;
            sum_nxt    = '0;
          end else begin
            size_nxt  = len_total[SIZE_W-1:0];
            count_nxt = OFS_BODY;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          emit     = 1'b1;
          data_nxt = rx_byte;
          if (count_plus < size_r) begin
            sum_nxt   = sum_r + rx_byte;
            count_nxt = count_plus[OFFSET_W-1:0];
          end else begin
            last_nxt   = 1'b1;
            status_nxt = (rx_byte == check) ? ST_GOOD : ST_BAD;
            phase_nxt  = PH_HUNT;
            count_nxt  = '0;
            size_nxt   = SIZE_RESET;
            sum_nxt    = '0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == marker_r) begin
            phase_nxt = PH_LEN;
            count_nxt = OFS_LEN;
            sum_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= '0;
      size_r  <= SIZE_RESET;
      sum_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      size_r  <= size_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      data_r   <= data_nxt;
      offset_r <= offset_nxt;
      last_r   <= last_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-BYTE_W-OFFSET_W){1'b0}}, offset_r, data_r};
  assign out_tlast  = last_r;
  assign out_tuser  = status_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[CFG_ADDR_W-1] == REG_START_MARKER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= MARKER_RESET;
    end else if (cfg_wr) begin
      marker_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_START_MARKER) begin
      cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, marker_r};
    end
  end

  `SFD_ASSERT(a_abandon_shape,
    (out_tvalid && out_tuser == ST_ABANDON) |-> (out_tlast && data_r == '0),
    "abandon word without last flag or with data")
  `SFD_ASSERT(a_last_has_verdict,
    out_tvalid |-> (out_tlast == (out_tuser != ST_PROGRESS)),
    "last flag and frame status disagree")
  `SFD_ASSERT(a_hunt_clean,
    (phase_r == PH_HUNT) |-> (count_r == '0 && sum_r == '0 && size_r == SIZE_RESET),
    "hunting with stale frame state")
  `SFD_ASSERT_NEVER(a_body_in_range,
    (phase_r == PH_BODY) && ({1'b0, count_r} >= size_r || count_r < OFS_BODY),
    "body offset outside frame")

endmodule

>>> verif/serial_frame_deframer_checksum_unit_checker.sv
// Checker for the serial frame deframer: tracks frames, predicts result words and compares.
`timescale 1ns / 1ps

module serial_frame_deframer_checksum_unit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [sfd_pkg::IN_TDATA_W-1:0]      in_tdata,    // [7:0] rx_byte
  input  logic                                in_tuser,    // [0] line_idle
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [sfd_pkg::OUT_TDATA_W-1:0]     out_tdata,   // [7:0] data_byte, [13:8] byte_offset
  input  logic                                out_tlast,
  input  logic [sfd_pkg::STATUS_W-1:0]        out_tuser,   // [1:0] frame_status
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  fail_count,
  output int                                  words_awaited
);
  import sfd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] MARKER_ADDR = CFG_ADDR_W'(4 * REG_START_MARKER);

  typedef struct packed {
    logic [1:0]          pad;
    logic [BYTE_W-1:0]   data;
    logic [OFFSET_W-1:0] offset;
    logic                last;
    status_t             status;
  } frame_word_t;

  phase_t              phase;
  logic [OFFSET_W-1:0] byte_count;
  logic [SIZE_W-1:0]   frame_size;
  logic [BYTE_W-1:0]   body_sum;
  logic [BYTE_W-1:0]   marker;
  frame_word_t         awaited_words[$];
  int                  mismatch_count = 0;

  assign fail_count = mismatch_count;

  function automatic void restart_hunt();
    phase      = PH_HUNT;
    byte_count = '0;
    frame_size = SIZE_W'(MAX_FRAME_BYTES);
    body_sum   = '0;
  endfunction

  // Advances the frame state by one byte; returns 1 when a result word follows.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, input logic idle,
                                      output frame_word_t w);
    w = '0;
    if (phase != PH_LEN && phase != PH_BODY) phase = PH_HUNT;
    if (idle) begin
      if (phase == PH_HUNT) return 1'b0;
      w.offset = byte_count;
      w.last   = 1'b1;
      w.status = ST_ABANDON;
      restart_hunt();
      return 1'b1;
    end
    case (phase)
      PH_HUNT: begin
        if (b == marker) begin
          phase      = PH_LEN;
          byte_count = OFFSET_W'(1);
          body_sum   = '0;
        end
        return 1'b0;
      end
      PH_LEN: begin
        if (int'(b) + FRAME_OVERHEAD > MAX_FRAME_BYTES) begin
          w.offset = OFFSET_W'(1);
          w.last   = 1'b1;
          w.status = ST_ABANDON;
          restart_hunt();
          return 1'b1;
        end
        frame_size = SIZE_W'(int'(b) + FRAME_OVERHEAD);
        byte_count = OFFSET_W'(2);
        phase      = PH_BODY;
        return 1'b0;
      end
      default: begin
        w.data   = b;
        w.offset = byte_count;
        if (int'(byte_count) + 1 < int'(frame_size)) begin
          body_sum   = body_sum + b;
          byte_count = byte_count + 1'b1;
          w.status   = ST_PROGRESS;
        end else begin
          w.last   = 1'b1;
          w.status = (b == BYTE_W'(CHECK_BASE - body_sum)) ? ST_GOOD : ST_BAD;
          restart_hunt();
        end
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    frame_word_t exp_w;
    frame_word_t got_w;
    if (!rst_n) begin
      restart_hunt();
      marker = MARKER_RESET;
      awaited_words.delete();
      words_awaited <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == MARKER_ADDR) begin
        if (cfg_pwrite) begin
          marker = cfg_pwdata[BYTE_W-1:0];
        end else if (cfg_prdata !== CFG_DATA_W'(marker)) begin
          $display("%0t: start marker read expected %h actual %h",
                   $time, CFG_DATA_W'(marker), cfg_prdata);
          mismatch_count++;
        end
      end
      // output first: a result word always belongs to an earlier input word
      if (out_tvalid && out_tready) begin
        got_w = {out_tdata[15:14], out_tdata[7:0], out_tdata[13:8], out_tlast, out_tuser};
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected result word expected none actual %h", $time, got_w);
          mismatch_count++;
        end else begin
          exp_w = awaited_words.pop_front();
          if (got_w !== exp_w) begin
            $display({"%0t: result word mismatch",
                      " expected pad=%h data=%h offset=%0d last=%b status=%0d",
                      " actual pad=%h data=%h offset=%0d last=%b status=%0d"},
                     $time, exp_w.pad, exp_w.data, exp_w.offset, exp_w.last,
                     exp_w.status, got_w.pad, got_w.data, got_w.offset, got_w.last,
                     got_w.status);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (deframe_byte(in_tdata[BYTE_W-1:0], in_tuser, exp_w)) begin
          awaited_words.push_back(exp_w);
        end
      end
      words_awaited <= awaited_words.size();
    end
  end

endmodule

>>> verif/tb_serial_frame_deframer_checksum_unit.sv
// Testbench top for the serial frame deframer: frame stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_serial_frame_deframer_checksum_unit;
  import sfd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] MARKER_ADDR = CFG_ADDR_W'(4 * REG_START_MARKER);
  localparam int LATENCY      = 1;
  localparam int LONG_HOLD    = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 250;
  localparam int QUIET_WORDS  = 100;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [7:0] rx_byte
  logic                   in_tuser;    // [0] line_idle
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // [7:0] data_byte, [13:8] byte_offset
  logic                   out_tlast;
  logic [STATUS_W-1:0]    out_tuser;   // [1:0] frame_status
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  int                     fail_count;
  int                     words_awaited;

  bit                     quiet = 1'b0;
  bit                     long_hold_req = 1'b0;
  logic [BYTE_W-1:0]      cur_marker = MARKER_RESET;
  int                     frame_words = 0;
  int                     idle_cycles = 0;

  serial_frame_deframer_checksum_unit i_dut (.*);

  serial_frame_deframer_checksum_unit_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver flow control
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic idle);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= idle;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // cut_at < 0: whole frame; else line goes idle in place of the byte at that body index
  task automatic send_frame(input int body_len, input bit good_sum, input int cut_at);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = '0;
    send_word(cur_marker, 1'b0);
    send_word(BYTE_W'(body_len), 1'b0);
    frame_words += 2;
    if (body_len + FRAME_OVERHEAD > MAX_FRAME_BYTES) return;
    for (int i = 0; i < body_len; i++) begin
      if (i == cut_at) begin
        send_word(BYTE_W'($urandom), 1'b1);
        frame_words++;
        return;
      end
      b = BYTE_W'($urandom);
      sum += b;
      send_word(b, 1'b0);
      frame_words++;
    end
    if (cut_at == body_len) send_word(BYTE_W'($urandom), 1'b1);
    else send_word(good_sum ? BYTE_W'(CHECK_BASE - sum) : BYTE_W'($urandom), 1'b0);
    frame_words++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (words_awaited == 0);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  // write then read back the start marker
  task automatic set_marker(input logic [BYTE_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MARKER_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_marker = value;
    @(posedge clk);
  endtask

  task automatic random_traffic(input int target, input bit quiet_tail);
    int len;
    int pick;
    int cut;
    frame_words = 0;
    while (frame_words < target) begin
      if (quiet_tail && frame_words > target - QUIET_WORDS) quiet = 1'b1;
      if ($urandom_range(0, 99) < 75) begin
        pick = $urandom_range(0, 19);
        if (pick < 12)      len = $urandom_range(0, 8);
        else if (pick < 16) len = $urandom_range(9, 61);
        else if (pick < 18) len = MAX_FRAME_BYTES - FRAME_OVERHEAD;
        else                len = $urandom_range(62, 255);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
        send_frame(len, $urandom_range(0, 2) != 0, cut);
      end else begin
        send_word(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle and noise while hunting, short frames, oversize lengths, idle drops
    send_word(8'h00, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_frame(0, 1'b1, -1);
    send_frame(0, 1'b0, -1);
    send_frame(62, 1'b1, -1);
    send_frame(255, 1'b1, -1);
    send_frame(2, 1'b1, 1);
    send_word(cur_marker, 1'b0);
    send_word(8'hFF, 1'b1);
    send_frame(2, 1'b1, -1);
    random_traffic(PHASE_WORDS, 1'b0);
    drain();

    set_marker(8'h00);
    long_hold_req = 1'b1;
    send_frame(MAX_FRAME_BYTES - FRAME_OVERHEAD, 1'b1, -1);
    random_traffic(PHASE_WORDS, 1'b0);
    drain();

    set_marker(8'hFF);
    random_traffic(PHASE_WORDS, 1'b0);
    drain();

    set_marker(BYTE_W'($urandom_range(1, 254)));
    random_traffic(PHASE_WORDS, 1'b1);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> serial_frame_deframer_checksum_unit.f
+incdir+hw/rtl
hw/rtl/sfd_pkg.sv
hw/rtl/serial_frame_deframer_checksum_unit.sv
verif/serial_frame_deframer_checksum_unit_checker.sv
verif/tb_serial_frame_deframer_checksum_unit.sv
